FILE: src/cips_pkg.sv
package cips_pkg;

	localparam int DATA_W  = 24;              // input and result field width
	localparam int ERR_W   = DATA_W + 1;      // loop error width
	localparam int D1_W    = ERR_W + 1;       // e - e1
	localparam int D2_W    = ERR_W + 2;       // e - 2*e1 + e2
	localparam int GAIN_W  = 16;              // Q8.8 gain
	localparam int LIM_W   = 23;              // clamp magnitude
	localparam int PROD_W  = GAIN_W + 1 + D2_W;
	localparam int FRAC_W  = 8;               // gain fraction bits
	localparam int SH_W    = PROD_W - FRAC_W;
	localparam int ACC_W   = 40;              // wide sum before clamp
	localparam int CFG_W   = LIM_W;           // widest register
	localparam int CFG_A_W = 3;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_POS_KP    = 3'd0,
		CFG_POS_KI    = 3'd1,
		CFG_POS_KD    = 3'd2,
		CFG_POS_LIMIT = 3'd3,
		CFG_SPD_KP    = 3'd4,
		CFG_SPD_KI    = 3'd5,
		CFG_SPD_KD    = 3'd6,
		CFG_SPD_LIMIT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GAIN_P,
		GAIN_I,
		GAIN_D
	} gain_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC,
		ST_CLAMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      err_en;
		logic      loop_spd;
		gain_sel_t gain;
		logic      mul_en;
		logic      acc_en;
		logic      clamp_en;
		logic      out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic speed_only;
	} dp_status_t;

endpackage

FILE: src/cips_ctrl.sv
module cips_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cips_pkg::dp_status_t  status,
	output cips_pkg::ctrl_cmd_t   cmd
);
	import cips_pkg::*;

	state_t state_q, state_d;
	logic   sel_q;        // set once the outer loop has finished
	logic   out_valid_q;
	logic   loop_spd;
	logic   out_free;

	assign loop_spd = sel_q | status.speed_only;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ERR;
			ST_ERR:   state_d = ST_MUL_P;
			ST_MUL_P: state_d = ST_MUL_I;
			ST_MUL_I: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_ACC;
			ST_ACC:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = loop_spd ? ST_DONE : ST_ERR;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.gain     = GAIN_P;
		cmd.loop_spd = loop_spd;
		case (state_q)
			ST_IDLE:  cmd.load_in = in_valid;
			ST_ERR:   cmd.err_en = 1'b1;
			ST_MUL_P: begin
				cmd.gain   = GAIN_P;
				cmd.mul_en = 1'b1;
			end
			ST_MUL_I: begin
				cmd.gain   = GAIN_I;
				cmd.mul_en = 1'b1;
				cmd.acc_en = 1'b1;
			end
			ST_MUL_D: begin
				cmd.gain   = GAIN_D;
				cmd.mul_en = 1'b1;
				cmd.acc_en = 1'b1;
			end
			ST_ACC:   cmd.acc_en = 1'b1;
			ST_CLAMP: cmd.clamp_en = 1'b1;
			ST_DONE:  cmd.out_load = out_free;
			default:  cmd.gain = GAIN_P;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				sel_q <= 1'b0;
			end else if (state_q == ST_CLAMP) begin
				sel_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/cips_dp.sv
module cips_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cips_pkg::CFG_A_W-1:0]        cfg_index,
	input  logic [cips_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                func,
	input  logic signed [cips_pkg::DATA_W-1:0]  reference,
	input  logic signed [cips_pkg::DATA_W-1:0]  angle_feedback,
	input  logic signed [cips_pkg::DATA_W-1:0]  speed_feedback,
	output logic signed [cips_pkg::DATA_W-1:0]  speed_command,
	output logic signed [cips_pkg::DATA_W-1:0]  drive,
	input  cips_pkg::ctrl_cmd_t                 cmd,
	output cips_pkg::dp_status_t                status
);
	import cips_pkg::*;

	// configuration
	logic [GAIN_W-1:0] pos_kp_q, pos_ki_q, pos_kd_q, spd_kp_q, spd_ki_q, spd_kd_q;
	logic [LIM_W-1:0]  pos_lim_q, spd_lim_q;

	// loop state
	logic signed [ERR_W-1:0]  pos_e1_q, pos_e2_q, spd_e1_q, spd_e2_q;
	logic signed [DATA_W-1:0] pos_acc_q, spd_acc_q;

	// latched item
	logic                     func_q;
	logic signed [DATA_W-1:0] ref_q, ang_q, spd_q;

	// working registers
	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] cmd_q, drive_q;

	logic signed [ERR_W-1:0]  e1, e2, err_new;
	logic signed [DATA_W-1:0] acc_sel, inner_ref;
	logic [GAIN_W-1:0]        kp, ki, kd, k;
	logic [LIM_W-1:0]         lim;
	logic signed [D1_W-1:0]   d1;
	logic signed [D2_W-1:0]   d2, opd;
	logic signed [GAIN_W:0]   gain_op;
	logic signed [PROD_W-1:0] product;
	logic signed [SH_W-1:0]   sh;
	logic signed [ACC_W-1:0]  lim_s, clamped;

	always_comb begin
		if (cmd.loop_spd) begin
			e1 = spd_e1_q; e2 = spd_e2_q; acc_sel = spd_acc_q;
			kp = spd_kp_q; ki = spd_ki_q; kd = spd_kd_q; lim = spd_lim_q;
		end else begin
			e1 = pos_e1_q; e2 = pos_e2_q; acc_sel = pos_acc_q;
			kp = pos_kp_q; ki = pos_ki_q; kd = pos_kd_q; lim = pos_lim_q;
		end
	end

	assign inner_ref = func_q ? ref_q : pos_acc_q;
	assign err_new   = cmd.loop_spd ? (ERR_W'(inner_ref) - ERR_W'(spd_q))
	                                : (ERR_W'(ref_q) - ERR_W'(ang_q));

	assign d1 = D1_W'(err_q) - D1_W'(e1);
	assign d2 = D2_W'(err_q) - (D2_W'(e1) <<< 1) + D2_W'(e2);

	always_comb begin
		case (cmd.gain)
			GAIN_P: begin
				k   = kp;
				opd = D2_W'(d1);
			end
			GAIN_I: begin
				k   = ki;
				opd = D2_W'(err_q);
			end
			GAIN_D: begin
				k   = kd;
				opd = d2;
			end
			default: begin
				k   = kp;
				opd = D2_W'(d1);
			end
		endcase
	end

	assign gain_op = $signed({1'b0, k});
	assign product = gain_op * opd;
	assign sh      = prod_q[PROD_W-1:FRAC_W];   // floor shift of the Q8.8 product

	assign lim_s = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
	always_comb begin
		if (acc_q > lim_s) begin
			clamped = lim_s;
		end else if (acc_q < -lim_s) begin
			clamped = -lim_s;
		end else begin
			clamped = acc_q;
		end
	end

	assign status.speed_only = func_q;
	assign speed_command     = cmd_q;
	assign drive             = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_kp_q  <= '0;
			pos_ki_q  <= '0;
			pos_kd_q  <= '0;
			pos_lim_q <= '0;
			spd_kp_q  <= '0;
			spd_ki_q  <= '0;
			spd_kd_q  <= '0;
			spd_lim_q <= '0;
			pos_e1_q  <= '0;
			pos_e2_q  <= '0;
			pos_acc_q <= '0;
			spd_e1_q  <= '0;
			spd_e2_q  <= '0;
			spd_acc_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_POS_KP:    pos_kp_q  <= cfg_data[GAIN_W-1:0];
					CFG_POS_KI:    pos_ki_q  <= cfg_data[GAIN_W-1:0];
					CFG_POS_KD:    pos_kd_q  <= cfg_data[GAIN_W-1:0];
					CFG_POS_LIMIT: pos_lim_q <= cfg_data[LIM_W-1:0];
					CFG_SPD_KP:    spd_kp_q  <= cfg_data[GAIN_W-1:0];
					CFG_SPD_KI:    spd_ki_q  <= cfg_data[GAIN_W-1:0];
					CFG_SPD_KD:    spd_kd_q  <= cfg_data[GAIN_W-1:0];
					CFG_SPD_LIMIT: spd_lim_q <= cfg_data[LIM_W-1:0];
					default:       pos_kp_q  <= pos_kp_q;
				endcase
			end
			if (cmd.clamp_en) begin
				if (cmd.loop_spd) begin
					spd_acc_q <= clamped[DATA_W-1:0];
					spd_e2_q  <= spd_e1_q;
					spd_e1_q  <= err_q;
				end else begin
					pos_acc_q <= clamped[DATA_W-1:0];
					pos_e2_q  <= pos_e1_q;
					pos_e1_q  <= err_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			ref_q  <= reference;
			ang_q  <= angle_feedback;
			spd_q  <= speed_feedback;
		end
		if (cmd.err_en) begin
			err_q <= err_new;
			acc_q <= ACC_W'(acc_sel);
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + ACC_W'(sh);
		end
		if (cmd.mul_en) begin
			prod_q <= product;
		end
		if (cmd.out_load) begin
			cmd_q   <= pos_acc_q;
			drive_q <= spd_acc_q;
		end
	end

endmodule

FILE: src/cascaded_incremental_pid_servo.sv
// Channel   Handshake               Payload
// input     in_valid / in_stall     func, reference, angle_feedback, speed_feedback
// output    out_valid / out_stall   speed_command, drive
// config    cfg_we                  cfg_index, cfg_data
//
// One shared 17x27 multiplier serves both loops; each loop steps through error,
// three products, last add and clamp. A position-mode item runs the outer loop
// and then the inner one, a speed-mode item only the inner; the next item can be
// taken in the cycle after the result is loaded into the output register.
// Reset clears gains, limits, stored errors and accumulated outputs.
// A stalled result holds in the output register; the next item may still be
// taken and runs until it has to wait for that register.
module cascaded_incremental_pid_servo (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [cips_pkg::DATA_W-1:0]  reference,
	input  logic signed [cips_pkg::DATA_W-1:0]  angle_feedback,
	input  logic signed [cips_pkg::DATA_W-1:0]  speed_feedback,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cips_pkg::DATA_W-1:0]  speed_command,
	output logic signed [cips_pkg::DATA_W-1:0]  drive,
	// register writes
	input  logic                                cfg_we,
	input  logic [cips_pkg::CFG_A_W-1:0]        cfg_index,
	input  logic [cips_pkg::CFG_W-1:0]          cfg_data
);
	import cips_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence the two loops and own both handshakes.
	cips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold registers, loop state and the shared multiply-accumulate path.
	cips_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.reference      (reference),
		.angle_feedback (angle_feedback),
		.speed_feedback (speed_feedback),
		.speed_command  (speed_command),
		.drive          (drive),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

FILE: dv/servo_checker.sv
`timescale 1ns / 1ps

// Watch the servo's channels, predict each result and compare it on arrival.
module servo_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               func,
	input  logic signed [cips_pkg::DATA_W-1:0] reference,
	input  logic signed [cips_pkg::DATA_W-1:0] angle_feedback,
	input  logic signed [cips_pkg::DATA_W-1:0] speed_feedback,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [cips_pkg::DATA_W-1:0] speed_command,
	input  logic signed [cips_pkg::DATA_W-1:0] drive,
	input  logic                               cfg_we,
	input  logic [cips_pkg::CFG_A_W-1:0]       cfg_index,
	input  logic [cips_pkg::CFG_W-1:0]         cfg_data,
	output int                                 fail_count,
	output int                                 pending
);
	import cips_pkg::*;

	typedef struct {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [LIM_W-1:0]  lim;
	} loop_gains_t;

	typedef struct {
		logic signed [ERR_W-1:0]  e1;
		logic signed [ERR_W-1:0]  e2;
		logic signed [DATA_W-1:0] acc;
	} loop_hist_t;

	typedef struct {
		logic signed [DATA_W-1:0] speed_command;
		logic signed [DATA_W-1:0] drive;
	} servo_result_t;

	loop_gains_t   pos_gains, spd_gains;
	loop_hist_t    pos_hist, spd_hist;
	servo_result_t predicted_outputs[$];
	servo_result_t want, got;
	logic signed [ERR_W-1:0]  pos_err, spd_err;
	logic signed [DATA_W-1:0] inner_target;
	int mismatches;

	// One incremental PID update: add the three floored Q8.8 terms, clamp, shift history.
	function automatic loop_hist_t pid_advance(loop_gains_t g, loop_hist_t h,
			logic signed [ERR_W-1:0] err);
		longint d1, d2, sum, lim;
		loop_hist_t nxt;
		d1  = longint'(err) - longint'(h.e1);
		d2  = longint'(err) - 2 * longint'(h.e1) + longint'(h.e2);
		lim = longint'(g.lim);
		sum = longint'(h.acc);
		sum += (longint'(g.kp) * d1) >>> FRAC_W;
		sum += (longint'(g.ki) * longint'(err)) >>> FRAC_W;
		sum += (longint'(g.kd) * d2) >>> FRAC_W;
		if (sum > lim)
			sum = lim;
		if (sum < -lim)
			sum = -lim;
		nxt.acc = sum[DATA_W-1:0];
		nxt.e2  = h.e1;
		nxt.e1  = err;
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gains = '{default: '0};
			spd_gains = '{default: '0};
			pos_hist = '{default: '0};
			spd_hist = '{default: '0};
			predicted_outputs.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_POS_KP:    pos_gains.kp  = cfg_data[GAIN_W-1:0];
					CFG_POS_KI:    pos_gains.ki  = cfg_data[GAIN_W-1:0];
					CFG_POS_KD:    pos_gains.kd  = cfg_data[GAIN_W-1:0];
					CFG_POS_LIMIT: pos_gains.lim = cfg_data[LIM_W-1:0];
					CFG_SPD_KP:    spd_gains.kp  = cfg_data[GAIN_W-1:0];
					CFG_SPD_KI:    spd_gains.ki  = cfg_data[GAIN_W-1:0];
					CFG_SPD_KD:    spd_gains.kd  = cfg_data[GAIN_W-1:0];
					CFG_SPD_LIMIT: spd_gains.lim = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end

			// compare before pushing: a new transfer can never be answered in the same cycle
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					$error("result transfer with no prediction pending: %s %0d drive %0d",
						"speed_command", speed_command, drive);
					mismatches++;
				end else begin
					want = predicted_outputs.pop_front();
					got.speed_command = speed_command;
					got.drive = drive;
					if (got.speed_command !== want.speed_command) begin
						$error("speed_command: expected %0d, actual %0d",
							want.speed_command, got.speed_command);
						mismatches++;
					end
					if (got.drive !== want.drive) begin
						$error("drive: expected %0d, actual %0d", want.drive, got.drive);
						mismatches++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (!func) begin
					pos_err = {reference[DATA_W-1], reference}
						- {angle_feedback[DATA_W-1], angle_feedback};
					pos_hist = pid_advance(pos_gains, pos_hist, pos_err);
					inner_target = pos_hist.acc;
				end else begin
					inner_target = reference;
				end
				spd_err = {inner_target[DATA_W-1], inner_target}
					- {speed_feedback[DATA_W-1], speed_feedback};
				spd_hist = pid_advance(spd_gains, spd_hist, spd_err);
				want.speed_command = pos_hist.acc;
				want.drive = spd_hist.acc;
				predicted_outputs.push_back(want);
			end

			pending <= predicted_outputs.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the cascaded servo; all prediction lives in the checker.
module tb_top;
	import cips_pkg::*;

	localparam int RUN_LIMIT    = 300000;  // cycles, far beyond the slowest legal run
	localparam int DRAIN_CYCLES = 16;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 56;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid;
	logic                     in_stall;
	logic                     func;
	logic signed [DATA_W-1:0] reference;
	logic signed [DATA_W-1:0] angle_feedback;
	logic signed [DATA_W-1:0] speed_feedback;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] speed_command;
	logic signed [DATA_W-1:0] drive;
	logic                     cfg_we;
	logic [CFG_A_W-1:0]       cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	int fail_count;
	int pending;

	// run statistics for the summary
	int items_sent;
	int speed_items;
	int settings_loaded;
	int cycle_count;

	// when clear, neither side inserts wait cycles
	bit idle_on;

	// slowly moving setpoint for the well-formed servo sequences
	logic signed [DATA_W-1:0] track_ref;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cascaded_incremental_pid_servo dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.reference      (reference),
		.angle_feedback (angle_feedback),
		.speed_feedback (speed_feedback),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.speed_command  (speed_command),
		.drive          (drive),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	servo_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.reference      (reference),
		.angle_feedback (angle_feedback),
		.speed_feedback (speed_feedback),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.speed_command  (speed_command),
		.drive          (drive),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Result side: after each transfer draw how many valid cycles to hold off the next one.
	// The count only runs down while a result is offered, so stalls land on real results.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				hold_left = idle_on ? $urandom_range(0, 5) : 0;
				out_stall <= (hold_left != 0);
			end else if (out_valid && out_stall) begin
				hold_left--;
				if (hold_left <= 0)
					out_stall <= 1'b0;
			end
		end
	end

	// Abort a hung run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[cascaded_incremental_pid_servo] ERROR");
		$finish;
	end

	// Offer one item, after a random gap while idling is on, and hold it until the transfer.
	// Called at a clock edge; returns at the edge of the transfer.
	task automatic send_item(logic f, logic signed [DATA_W-1:0] tgt,
			logic signed [DATA_W-1:0] ang, logic signed [DATA_W-1:0] spd);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		reference <= tgt;
		angle_feedback <= ang;
		speed_feedback <= spd;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		items_sent++;
		if (f)
			speed_items++;
	endtask

	// Drop valid and wait until every predicted result has been taken.
	task automatic drain;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Load every register; gain writes carry junk above bit 15 that the block must drop.
	task automatic load_gains(logic [GAIN_W-1:0] pkp, logic [GAIN_W-1:0] pki,
			logic [GAIN_W-1:0] pkd, logic [LIM_W-1:0] plim,
			logic [GAIN_W-1:0] skp, logic [GAIN_W-1:0] ski,
			logic [GAIN_W-1:0] skd, logic [LIM_W-1:0] slim);
		write_reg(CFG_POS_KP, {(CFG_W-GAIN_W)'($urandom), pkp});
		write_reg(CFG_POS_KI, {(CFG_W-GAIN_W)'($urandom), pki});
		write_reg(CFG_POS_KD, {(CFG_W-GAIN_W)'($urandom), pkd});
		write_reg(CFG_POS_LIMIT, plim);
		write_reg(CFG_SPD_KP, {(CFG_W-GAIN_W)'($urandom), skp});
		write_reg(CFG_SPD_KI, {(CFG_W-GAIN_W)'($urandom), ski});
		write_reg(CFG_SPD_KD, {(CFG_W-GAIN_W)'($urandom), skd});
		write_reg(CFG_SPD_LIMIT, slim);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2, 3:    return GAIN_W'($urandom_range(0, 'h200));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] rand_limit();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return LIM_W'($urandom_range(1, 1000));
			default: return LIM_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] small_value();
		return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
	endfunction

	// Bias toward the corners and toward zero, else anything in range.
	function automatic logic signed [DATA_W-1:0] rand_field();
		case ($urandom_range(0, 9))
			0:       return 24'sh7FFFFF;
			1:       return 24'sh800000;
			2:       return '0;
			3, 4:    return small_value();
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Mostly a servo tracking a setpoint with small errors; the rest is raw noise.
	task automatic send_random_item;
		logic f;
		logic signed [DATA_W-1:0] tgt, ang, spd;
		f = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 9) < 6) begin
			if ($urandom_range(0, 7) == 0)
				track_ref = rand_field();
			else
				track_ref = track_ref + small_value();
			tgt = track_ref;
			ang = track_ref + small_value();
			spd = small_value();
		end else begin
			tgt = rand_field();
			ang = rand_field();
			spd = rand_field();
		end
		send_item(f, tgt, ang, spd);
	endtask

	initial begin : stimulus
		in_valid = 1'b0;
		func = 1'b0;
		reference = '0;
		angle_feedback = '0;
		speed_feedback = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_POS_KP;
		cfg_data = '0;
		items_sent = 0;
		speed_items = 0;
		settings_loaded = 0;
		idle_on = 1'b1;
		track_ref = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// moderate gains, wide limits: corners of every field in both modes
		load_gains(16'h0100, 16'h0040, 16'h0080, '1, 16'h0180, 16'h0020, 16'h0100, '1);
		send_item(1'b0, '0, '0, '0);
		send_item(1'b0, 24'sh7FFFFF, 24'sh800000, '0);
		send_item(1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
		send_item(1'b0, 24'sh000100, 24'sh000000, 24'sh000010);
		send_item(1'b0, -24'sh000100, 24'sh000000, -24'sh000010);
		// speed mode holds the outer output while the inner loop moves
		send_item(1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
		send_item(1'b1, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(1'b1, '0, 24'sh123456, '0);
		send_item(1'b0, 24'sh000001, '0, '0);
		drain;

		// zero limits force both outputs to zero
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
		send_item(1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
		send_item(1'b1, 24'sh800000, '0, 24'sh7FFFFF);
		send_item(1'b0, 24'sh800000, 24'sh7FFFFF, '0);
		drain;

		// full gains, full limits: drive the clamp hard both ways
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
		send_item(1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
		send_item(1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
		send_item(1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(1'b1, 24'sh7FFFFF, '0, 24'sh800000);
		send_item(1'b1, 24'sh800000, '0, 24'sh7FFFFF);
		send_item(1'b0, '0, '0, '0);
		drain;

		// random settings; two of the phases run without any idling
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			idle_on = (phase % 4) != 3;
			load_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
				rand_gain(), rand_gain(), rand_gain(), rand_limit());
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_item();
			drain;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transfers (%0d speed-only) across %0d register settings,",
			items_sent, speed_items, settings_loaded);
		$display("including zero and full gains and limits, with and without idling.");
		if (fail_count == 0 && pending == 0)
			$display("[cascaded_incremental_pid_servo] OK");
		else
			$display("[cascaded_incremental_pid_servo] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
src/cips_pkg.sv
src/cips_ctrl.sv
src/cips_dp.sv
src/cascaded_incremental_pid_servo.sv
dv/servo_checker.sv
dv/tb_top.sv
